[src/sgrcm_pkg.sv]
// ----------------------------------------------------------------------------
// sgrcm_pkg
// shared types and constants for the stereo gain ramp and channel mix block
// ----------------------------------------------------------------------------
`default_nettype none

package sgrcm_pkg;

  localparam int SampleW  = 16;
  localparam int GainW    = 16;
  localparam int PctW     = 7;
  localparam int ModeW    = 2;
  localparam int ProdW    = 22;   // clamped target times percent, at most 3276800
  localparam int RecipW   = 22;
  localparam int DivShift = 28;
  localparam int GainShift = 15;
  localparam int RampShift = 8;   // divide by 256
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  localparam logic [GainW-1:0]  UNITY_Q15   = 16'h8000;
  localparam logic [PctW-1:0]   PCT_MAX     = 7'd100;
  // ceil(2^28 / 100); exact floor division for dividends below 2^28 / 44
  localparam logic [RecipW-1:0] RECIP_100   = 22'd2684355;

  // channel modes
  localparam logic [ModeW-1:0] MODE_STEREO = 2'd0;
  localparam logic [ModeW-1:0] MODE_LEFT   = 2'd1;
  localparam logic [ModeW-1:0] MODE_RIGHT  = 2'd2;
  localparam logic [ModeW-1:0] MODE_MONO   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MAX_VOLUME = 2'd0;
  localparam logic [1:0] REG_MODE       = 2'd1;
  localparam logic [1:0] REG_MIX_DONE   = 2'd2;
  localparam logic [1:0] REG_GAIN_BYP   = 2'd3;

  typedef struct packed {
    logic load_in;   // capture a new item and form target times percent
    logic do_div;    // divide by 100 through reciprocal multiply
    logic do_ramp;   // step the kept gain
    logic do_scale;  // multiply both samples by the gain
    logic load_out;  // apply channel mode into the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } status_t;

  typedef struct packed {
    logic [PctW-1:0]  max_volume_percent;
    logic [ModeW-1:0] mode_select;
    logic             mix_done_downstream;
    logic             gain_bypass;
  } cfg_t;

endpackage

`default_nettype wire

[src/sgrcm_ctrl.sv]
// ----------------------------------------------------------------------------
// sgrcm_ctrl
// sequencer for one item: divide, ramp, scale, then mix into the output
// ----------------------------------------------------------------------------
`default_nettype none

module sgrcm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sgrcm_pkg::status_t status,
  output sgrcm_pkg::cmd_t       cmd
);
  import sgrcm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_RAMP   = 5'b00100,
    ST_SCALE  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // the next item may enter in the cycle the finished one leaves
  assign in_ready = (state == ST_IDLE) || ((state == ST_FINISH) && status.out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = accept;
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.do_div = 1'b1;
        state_next = ST_RAMP;
      end
      ST_RAMP: begin
        cmd.do_ramp = 1'b1;
        state_next  = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.do_scale = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = accept ? ST_DIV : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[src/sgrcm_dp.sv]
// ----------------------------------------------------------------------------
// sgrcm_dp
// datapath: target scaling, gain ramp, sample scaling, channel mode, output
// ----------------------------------------------------------------------------
`default_nettype none

module sgrcm_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sgrcm_pkg::cmd_t     cmd,
  output sgrcm_pkg::status_t       status,
  input  wire sgrcm_pkg::cfg_t     cfg,
  input  wire logic signed [15:0]  left_in,
  input  wire logic signed [15:0]  right_in,
  input  wire logic [15:0]         volume_target,
  input  wire logic                buffer_end,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       left_out,
  output logic signed [15:0]       right_out,
  output logic [15:0]              gain_used,
  output logic                     buffer_end_out
);
  import sgrcm_pkg::*;

  // item registers
  logic signed [SampleW-1:0] left_r;
  logic signed [SampleW-1:0] right_r;
  logic                      end_r;
  logic [ProdW-1:0]          tgt_prod;
  logic [GainW-1:0]          target;
  logic [GainW-1:0]          used;
  logic signed [SampleW-1:0] left_s;
  logic signed [SampleW-1:0] right_s;

  // ramp state
  logic [GainW-1:0] gain_now;
  logic             gain_started;
  logic [GainW-1:0] gain_now_next;
  logic             gain_started_next;
  logic [GainW-1:0] used_next;

  logic [GainW-1:0]          tgt_clamp;
  logic [PctW-1:0]           pct_sat;
  logic [ProdW-1:0]          tgt_prod_next;
  logic [ProdW+RecipW-1:0]   div_prod;
  logic signed [GainW:0]     diff;
  logic signed [GainW:0]     diff_adj;
  logic signed [GainW:0]     step;
  logic signed [2*SampleW:0] mul_l;
  logic signed [2*SampleW:0] mul_r;
  logic signed [SampleW:0]   sum;
  logic signed [SampleW:0]   sum_adj;
  logic signed [SampleW-1:0] mono;
  logic signed [SampleW-1:0] mix_l;
  logic signed [SampleW-1:0] mix_r;

  assign status.out_free = !out_valid || out_ready;

  // target clamp and percent ceiling
  always_comb begin
    tgt_clamp     = (volume_target > UNITY_Q15) ? UNITY_Q15 : volume_target;
    pct_sat       = (cfg.max_volume_percent > PCT_MAX) ? PCT_MAX : cfg.max_volume_percent;
    tgt_prod_next = ProdW'(tgt_clamp) * ProdW'(pct_sat);
  end

  // divide by 100
  assign div_prod = (ProdW+RecipW)'(tgt_prod) * (ProdW+RecipW)'(RECIP_100);

  // ramp step: difference over 256 truncated toward zero, at least one
  always_comb begin
    diff     = $signed({1'b0, target}) - $signed({1'b0, gain_now});
    diff_adj = diff[GainW] ? (diff + (GainW+1)'(255)) : diff;
    step     = diff_adj >>> RampShift;
    if (step == '0) begin
      step = diff[GainW] ? -(GainW+1)'(1) : (GainW+1)'(1);
    end
    gain_now_next     = gain_now;
    gain_started_next = gain_started;
    if (!gain_started) begin
      gain_now_next     = target;
      gain_started_next = 1'b1;
    end else if (gain_now != target) begin
      gain_now_next = gain_now + step[GainW-1:0];
    end
    used_next = cfg.gain_bypass ? UNITY_Q15 : gain_now_next;
  end

  // sample scaling, unity gain when bypassed gives the sample back
  assign mul_l = left_r  * $signed({1'b0, used});
  assign mul_r = right_r * $signed({1'b0, used});

  // channel mode
  always_comb begin
    sum     = $signed({left_s[SampleW-1], left_s}) + $signed({right_s[SampleW-1], right_s});
    sum_adj = sum + $signed({{SampleW{1'b0}}, sum[SampleW]});
    mono    = sum_adj[SampleW:1];
    mix_l   = left_s;
    mix_r   = right_s;
    if (!cfg.mix_done_downstream) begin
      case (cfg.mode_select)
        MODE_STEREO: begin
          mix_l = left_s;
          mix_r = right_s;
        end
        MODE_LEFT: begin
          mix_r = left_s;
        end
        MODE_RIGHT: begin
          mix_l = right_s;
        end
        MODE_MONO: begin
          mix_l = mono;
          mix_r = mono;
        end
        default: begin
          mix_l = left_s;
          mix_r = right_s;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      left_r   <= left_in;
      right_r  <= right_in;
      end_r    <= buffer_end;
      tgt_prod <= tgt_prod_next;
    end
    if (cmd.do_div) begin
      target <= div_prod[DivShift+GainW-1:DivShift];
    end
    if (cmd.do_ramp) begin
      used <= used_next;
    end
    if (cmd.do_scale) begin
      left_s  <= mul_l[GainShift+SampleW-1:GainShift];
      right_s <= mul_r[GainShift+SampleW-1:GainShift];
    end
    if (cmd.load_out) begin
      left_out       <= mix_l;
      right_out      <= mix_r;
      gain_used      <= used;
      buffer_end_out <= end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_now     <= '0;
      gain_started <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.do_ramp && !cfg.gain_bypass) begin
        gain_now     <= gain_now_next;
        gain_started <= gain_started_next;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/stereo_gain_ramp_channel_mix_top.sv]
// ----------------------------------------------------------------------------
// stereo_gain_ramp_channel_mix_top
// smoothed volume ramp on a stereo frame, followed by a channel mode
// ----------------------------------------------------------------------------
// One item is one stereo frame with a Q15 volume target. The target is clamped
// to unity, scaled by the max volume percent (floor of target*percent/100,
// done as a multiply by a reciprocal), and a kept gain steps toward it by the
// difference over 256 truncated toward zero, at least one step. The very first
// frame after reset loads the gain with the target. Both samples are scaled by
// the gain (floor of s*g/2^15), then the channel mode picks stereo, left to
// both, right to both or the truncated mono average. Gain bypass leaves the
// samples and the kept gain alone and reports unity; the mix-done flag skips
// the channel mode. An item passes through a four-step sequencer (divide,
// ramp, scale, mix), and the next item is taken in the same cycle the
// previous result moves into the output register, so a new item is not taken
// before the previous one has reached that register. A result waiting in the
// output register holds the sequencer in its last step, which backs up
// in_ready.
// Registers on the APB port: 0x0 max_volume_percent (7 bits, reset 100,
// values above 100 act as 100), 0x4 mode_select (2 bits), 0x8
// mix_done_downstream (1 bit), 0xC gain_bypass (1 bit). Write them only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_gain_ramp_channel_mix_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // apb-style configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sgrcm_pkg::AddrW-1:0]    paddr,
  input  wire logic [sgrcm_pkg::DataW-1:0]    pwdata,
  output logic      [sgrcm_pkg::DataW-1:0]    prdata,
  output logic                                pready,
  // input items
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [15:0]             left_in,
  input  wire logic signed [15:0]             right_in,
  input  wire logic [15:0]                    volume_target,
  input  wire logic                           buffer_end,
  // result items
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [15:0]                  left_out,
  output logic signed [15:0]                  right_out,
  output logic [15:0]                         gain_used,
  output logic                                buffer_end_out
);
  import sgrcm_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  status_t    status;
  logic       wr_en;
  logic [1:0] reg_idx;

  // register file, byte address 4*index
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_volume_percent  <= PCT_MAX;
      cfg.mode_select         <= MODE_STEREO;
      cfg.mix_done_downstream <= 1'b0;
      cfg.gain_bypass         <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_VOLUME: cfg.max_volume_percent  <= pwdata[PctW-1:0];
        REG_MODE:       cfg.mode_select         <= pwdata[ModeW-1:0];
        REG_MIX_DONE:   cfg.mix_done_downstream <= pwdata[0];
        REG_GAIN_BYP:   cfg.gain_bypass         <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_MAX_VOLUME: prdata = DataW'(cfg.max_volume_percent);
      REG_MODE:       prdata = DataW'(cfg.mode_select);
      REG_MIX_DONE:   prdata = DataW'(cfg.mix_done_downstream);
      REG_GAIN_BYP:   prdata = DataW'(cfg.gain_bypass);
      default:        prdata = '0;
    endcase
  end

  // sequencer
  sgrcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and output register
  sgrcm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg            (cfg),
    .left_in        (left_in),
    .right_in       (right_in),
    .volume_target  (volume_target),
    .buffer_end     (buffer_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_out       (left_out),
    .right_out      (right_out),
    .gain_used      (gain_used),
    .buffer_end_out (buffer_end_out)
  );

endmodule

`default_nettype wire

[test/stereo_gain_ramp_channel_mix_top_tb.sv]
// ----------------------------------------------------------------------------
// stereo_gain_ramp_channel_mix_top_tb
// self-checking bench for the stereo gain ramp and channel mix block
// ----------------------------------------------------------------------------
// A table of hand-picked frames runs first. Extremes of the samples and the
// target, every channel mode, the mix-done skip, gain bypass and the ceiling
// above 100 percent are all in the table. Rows whose result is obvious carry
// the answer; the rest are checked against a local model of the gain ramp.
// Random phases follow, each with a fresh register setting. Some phases hold
// the target still or near the kept gain, so the ramp settles and the step of
// one is reached. Both sides of the stream idle in random bursts. The output
// side is held off once for a long stretch, and the input side pauses once
// mid-phase until every frame is back. The last phase runs with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_gain_ramp_channel_mix_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgrcm_pkg::*;

  localparam int PERCENT_DIV = 100;
  localparam int RAMP_DIV    = 256;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_CYCLES = 120;   // long output hold-off
  localparam int SETTLE      = 8;     // extra wait after the last result comes back
  localparam int LIMIT       = 400000;

  typedef struct packed {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
    logic [GainW-1:0]   target;
    logic               last;
  } frame_t;

  typedef struct packed {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
    logic [GainW-1:0]   gain;
    logic               last;
  } result_t;

  typedef struct packed {
    cfg_t    cfg;
    frame_t  frame;
    logic    has_answer;
    result_t answer;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [15:0]       left_in = '0;
  logic [15:0]       right_in = '0;
  logic [15:0]       volume_target = '0;
  logic              buffer_end = 1'b0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       left_out;
  logic [15:0]       right_out;
  logic [15:0]       gain_used;
  logic              buffer_end_out;

  // local copy of the registers and the ramp state
  cfg_t              mix_cfg = '{PCT_MAX, MODE_STEREO, 1'b0, 1'b0};
  logic [GainW-1:0]  gain_kept = '0;
  logic              gain_primed = 1'b0;

  result_t           due_frames[$];
  plan_row_t         directed_frames[$];
  int                fails = 0;
  int                cycle_count = 0;
  bit                idle_on = 1'b1;
  bit                hold_req = 1'b0;

  stereo_gain_ramp_channel_mix_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .left_in        (left_in),
    .right_in       (right_in),
    .volume_target  (volume_target),
    .buffer_end     (buffer_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_out       (left_out),
    .right_out      (right_out),
    .gain_used      (gain_used),
    .buffer_end_out (buffer_end_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("stereo_gain_ramp_channel_mix_top_tb failed");
      $finish;
    end
  end

  // one frame through the ramp and the channel mode, advancing the kept gain
  function automatic result_t predict_mix(frame_t f);
    int l, r, tgt, pct, goal, diff, step, nxt, m;
    result_t o;
    l = $signed(f.left);
    r = $signed(f.right);
    o.gain = UNITY_Q15;
    o.last = f.last;
    if (!mix_cfg.gain_bypass) begin
      // ceiling above 100 acts as 100, target above unity acts as unity
      pct = (mix_cfg.max_volume_percent > PCT_MAX) ? int'(PCT_MAX)
                                                   : int'(mix_cfg.max_volume_percent);
      tgt = (f.target > UNITY_Q15) ? int'(UNITY_Q15) : int'(f.target);
      goal = tgt * pct / PERCENT_DIV;
      if (!gain_primed) begin
        // first frame after reset loads the target with no step
        gain_kept = goal[15:0];
        gain_primed = 1'b1;
      end else if (int'(gain_kept) != goal) begin
        diff = goal - int'(gain_kept);
        step = diff / RAMP_DIV;
        if (step == 0) step = (diff > 0) ? 1 : -1;
        nxt = int'(gain_kept) + step;
        gain_kept = nxt[15:0];
      end
      o.gain = gain_kept;
      l = (l * int'(gain_kept)) >>> GainShift;
      r = (r * int'(gain_kept)) >>> GainShift;
    end
    if (!mix_cfg.mix_done_downstream) begin
      case (mix_cfg.mode_select)
        MODE_LEFT:  r = l;
        MODE_RIGHT: l = r;
        MODE_MONO: begin
          m = (l + r) / 2;
          l = m;
          r = m;
        end
        default: ;
      endcase
    end
    o.left = l[15:0];
    o.right = r[15:0];
    return o;
  endfunction

  function automatic plan_row_t plan_frame(int pct, logic [ModeW-1:0] mode, bit mixd,
                                           bit byp, int l, int r, int tgt, bit last,
                                           bit has, int el, int er, int eg);
    plan_row_t row;
    row.cfg.max_volume_percent = pct[PctW-1:0];
    row.cfg.mode_select = mode;
    row.cfg.mix_done_downstream = mixd;
    row.cfg.gain_bypass = byp;
    row.frame.left = l[15:0];
    row.frame.right = r[15:0];
    row.frame.target = tgt[15:0];
    row.frame.last = last;
    row.has_answer = has;
    row.answer.left = el[15:0];
    row.answer.right = er[15:0];
    row.answer.gain = eg[15:0];
    row.answer.last = last;
    return row;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 19))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_VOLUME: mix_cfg.max_volume_percent = val[PctW-1:0];
      REG_MODE:       mix_cfg.mode_select = val[ModeW-1:0];
      REG_MIX_DONE:   mix_cfg.mix_done_downstream = val[0];
      REG_GAIN_BYP:   mix_cfg.gain_bypass = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop offering and wait until every frame in flight has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic set_config(input cfg_t c, input bit all);
    if (!all && c == mix_cfg) return;
    drain_results();
    if (all || c.max_volume_percent != mix_cfg.max_volume_percent)
      write_reg(REG_MAX_VOLUME, 32'(c.max_volume_percent));
    if (all || c.mode_select != mix_cfg.mode_select)
      write_reg(REG_MODE, 32'(c.mode_select));
    if (all || c.mix_done_downstream != mix_cfg.mix_done_downstream)
      write_reg(REG_MIX_DONE, 32'(c.mix_done_downstream));
    if (all || c.gain_bypass != mix_cfg.gain_bypass)
      write_reg(REG_GAIN_BYP, 32'(c.gain_bypass));
  endtask

  // hold the item until accepted; valid stays up for a following item
  task automatic offer_frame(input frame_t f, input bit has_answer, input result_t answer);
    result_t predicted;
    in_valid <= 1'b1;
    left_in <= f.left;
    right_in <= f.right;
    volume_target <= f.target;
    buffer_end <= f.last;
    do @(posedge clk); while (!in_ready);
    predicted = predict_mix(f);
    due_frames.push_back(has_answer ? answer : predicted);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // output side: check each accepted item, then pick the next ready
  initial begin : result_side
    result_t want;
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (due_frames.size() == 0) begin
          $error("result item with nothing pending");
          fails++;
        end else begin
          want = due_frames.pop_front();
          if (left_out !== want.left) begin
            $error("left_out: expected %0d, got %0d", $signed(want.left), $signed(left_out));
            fails++;
          end
          if (right_out !== want.right) begin
            $error("right_out: expected %0d, got %0d", $signed(want.right),
                   $signed(right_out));
            fails++;
          end
          if (gain_used !== want.gain) begin
            $error("gain_used: expected %0d, got %0d", want.gain, gain_used);
            fails++;
          end
          if (buffer_end_out !== want.last) begin
            $error("buffer_end_out: expected %0d, got %0d", want.last, buffer_end_out);
            fails++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        // long hold-off: the block fills and in_ready must drop
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  initial begin : stimulus
    frame_t f;
    cfg_t c;
    result_t none;
    int style, base, buflen, pct_eff, tgt_v;
    none = '0;

    // stereo rows, ramp from unity, then modes, bypass, ceilings
    directed_frames.push_back(plan_frame(100, MODE_STEREO, 0, 0, 16384, -16384, 32768, 0,
                                         1, 16384, -16384, 32768));
    directed_frames.push_back(plan_frame(100, MODE_STEREO, 0, 0, 32767, -32768, 65535, 1,
                                         1, 32767, -32768, 32768));
    directed_frames.push_back(plan_frame(100, MODE_STEREO, 0, 0, -1, 1, 0, 0,
                                         1, -1, 0, 32640));
    directed_frames.push_back(plan_frame(100, MODE_STEREO, 0, 0, 0, 0, 32767, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(100, MODE_STEREO, 0, 0, -32768, 32767, 32769, 1,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(100, MODE_LEFT, 0, 0, 1234, -4321, 32768, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(100, MODE_RIGHT, 0, 0, 1234, -4321, 32768, 1,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(100, MODE_MONO, 0, 0, -3, 0, 32768, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(100, MODE_MONO, 0, 0, 32767, 32767, 32768, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(100, MODE_MONO, 1, 0, 500, -700, 32768, 0,
                                         0, 0, 0, 0));
    // gain bypass: samples pass, unity reported, kept gain untouched
    directed_frames.push_back(plan_frame(100, MODE_MONO, 1, 1, -32768, 32767, 123, 1,
                                         1, -32768, 32767, 32768));
    directed_frames.push_back(plan_frame(100, MODE_MONO, 0, 1, 32767, 32767, 0, 0,
                                         1, 32767, 32767, 32768));
    // mono average truncates toward zero
    directed_frames.push_back(plan_frame(100, MODE_MONO, 0, 1, -32768, -32767, 65535, 1,
                                         1, -32767, -32767, 32768));
    directed_frames.push_back(plan_frame(100, MODE_LEFT, 0, 1, -5, 9, 0, 0,
                                         1, -5, -5, 32768));
    // zero ceiling ramps down, ceiling above 100 saturates
    directed_frames.push_back(plan_frame(0, MODE_STEREO, 0, 0, 32767, -32768, 32768, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(0, MODE_STEREO, 0, 0, -32768, 32767, 65535, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(127, MODE_STEREO, 0, 0, 1, -1, 32768, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(101, MODE_RIGHT, 0, 0, 20000, -20000, 40000, 1,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(50, MODE_STEREO, 0, 0, 16, -16, 65535, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(1, MODE_MONO, 0, 0, 32767, -1, 32768, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(99, MODE_STEREO, 0, 0, 12345, -12345, 3, 0,
                                         0, 0, 0, 0));
    directed_frames.push_back(plan_frame(100, MODE_STEREO, 0, 0, 0, -1, 0, 1,
                                         0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_frames[i]) begin
      set_config(directed_frames[i].cfg, 1'b0);
      offer_frame(directed_frames[i].frame, directed_frames[i].has_answer,
                  directed_frames[i].answer);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       c.max_volume_percent = 7'd0;
        1:       c.max_volume_percent = PCT_MAX;
        2:       c.max_volume_percent = 7'd127;
        3:       c.max_volume_percent = 7'($urandom_range(101, 127));
        default: c.max_volume_percent = 7'($urandom_range(1, 99));
      endcase
      c.mode_select = 2'($urandom_range(0, 3));
      c.mix_done_downstream = ($urandom_range(0, 3) == 0);
      c.gain_bypass = ($urandom_range(0, 4) == 0);
      set_config(c, 1'b1);
      // final phase runs flat out on both sides
      idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      style = $urandom_range(0, 3);
      buflen = $urandom_range(4, 32);
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(32768, 65535)
                                          : $urandom_range(0, 32768);
      pct_eff = (c.max_volume_percent > PCT_MAX) ? int'(PCT_MAX)
                                                 : int'(c.max_volume_percent);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 5) hold_req = 1'b1;
        if (ph == 4 && k == 20) drain_results();
        case (style)
          0: tgt_v = base;
          1: begin
            // aim near the kept gain so the ramp lands and holds
            if (pct_eff == 0 || $urandom_range(0, 9) == 0) tgt_v = $urandom_range(0, 65535);
            else tgt_v = int'(gain_kept) * PERCENT_DIV / pct_eff
                         + int'($urandom_range(0, 6)) - 3;
          end
          2: tgt_v = $urandom_range(0, 65535);
          default: tgt_v = ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(0, 32768);
        endcase
        if (tgt_v < 0) tgt_v = 0;
        if (tgt_v > 65535) tgt_v = 65535;
        f.left = rand_sample();
        f.right = rand_sample();
        f.target = tgt_v[15:0];
        f.last = ((k % buflen) == buflen - 1) ^ ($urandom_range(0, 19) == 0);
        offer_frame(f, 1'b0, none);
      end
    end

    drain_results();
    if (fails == 0) begin
      $display("stereo_gain_ramp_channel_mix_top_tb passed");
    end else begin
      $display("stereo_gain_ramp_channel_mix_top_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
